// ===== sv/adnd_pkg.sv =====
// ----------------------------------------------------------------------------
// adnd_pkg
// Types, constants and decode functions shared by the ADPCM nibble decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package adnd_pkg;

  localparam logic [6:0]  StepIndexMax = 7'd88;
  localparam logic [15:0] SampleMax    = 16'h7fff;
  localparam logic [15:0] SampleMin    = 16'h8000;

  // Decoder state that carries from one nibble to the next.
  typedef struct packed {
    logic [15:0] pred;
    logic [6:0]  idx;
  } nib_state_t;

  // Step size table, 89 entries.
  function automatic logic [14:0] step_lookup(input logic [6:0] idx);
    logic [14:0] step;
    unique case (idx)
      7'd0:  step = 15'd7;     7'd1:  step = 15'd8;     7'd2:  step = 15'd9;
      7'd3:  step = 15'd10;    7'd4:  step = 15'd11;    7'd5:  step = 15'd12;
      7'd6:  step = 15'd13;    7'd7:  step = 15'd14;    7'd8:  step = 15'd16;
      7'd9:  step = 15'd17;    7'd10: step = 15'd19;    7'd11: step = 15'd21;
      7'd12: step = 15'd23;    7'd13: step = 15'd25;    7'd14: step = 15'd28;
      7'd15: step = 15'd31;    7'd16: step = 15'd34;    7'd17: step = 15'd37;
      7'd18: step = 15'd41;    7'd19: step = 15'd45;    7'd20: step = 15'd50;
      7'd21: step = 15'd55;    7'd22: step = 15'd60;    7'd23: step = 15'd66;
      7'd24: step = 15'd73;    7'd25: step = 15'd80;    7'd26: step = 15'd88;
      7'd27: step = 15'd97;    7'd28: step = 15'd107;   7'd29: step = 15'd118;
      7'd30: step = 15'd130;   7'd31: step = 15'd143;   7'd32: step = 15'd157;
      7'd33: step = 15'd173;   7'd34: step = 15'd190;   7'd35: step = 15'd209;
      7'd36: step = 15'd230;   7'd37: step = 15'd253;   7'd38: step = 15'd279;
      7'd39: step = 15'd307;   7'd40: step = 15'd337;   7'd41: step = 15'd371;
      7'd42: step = 15'd408;   7'd43: step = 15'd449;   7'd44: step = 15'd494;
      7'd45: step = 15'd544;   7'd46: step = 15'd598;   7'd47: step = 15'd658;
      7'd48: step = 15'd724;   7'd49: step = 15'd796;   7'd50: step = 15'd876;
      7'd51: step = 15'd963;   7'd52: step = 15'd1060;  7'd53: step = 15'd1166;
      7'd54: step = 15'd1282;  7'd55: step = 15'd1411;  7'd56: step = 15'd1552;
      7'd57: step = 15'd1707;  7'd58: step = 15'd1878;  7'd59: step = 15'd2066;
      7'd60: step = 15'd2272;  7'd61: step = 15'd2499;  7'd62: step = 15'd2749;
      7'd63: step = 15'd3024;  7'd64: step = 15'd3327;  7'd65: step = 15'd3660;
      7'd66: step = 15'd4026;  7'd67: step = 15'd4428;  7'd68: step = 15'd4871;
      7'd69: step = 15'd5358;  7'd70: step = 15'd5894;  7'd71: step = 15'd6484;
      7'd72: step = 15'd7132;  7'd73: step = 15'd7845;  7'd74: step = 15'd8630;
      7'd75: step = 15'd9493;  7'd76: step = 15'd10442; 7'd77: step = 15'd11487;
      7'd78: step = 15'd12635; 7'd79: step = 15'd13899; 7'd80: step = 15'd15289;
      7'd81: step = 15'd16818; 7'd82: step = 15'd18500; 7'd83: step = 15'd20350;
      7'd84: step = 15'd22385; 7'd85: step = 15'd24623; 7'd86: step = 15'd27086;
      7'd87: step = 15'd29794; 7'd88: step = 15'd32767;
      default: step = 15'd32767;
    endcase
    return step;
  endfunction

  // Step index adjustment by code magnitude.
  function automatic logic [7:0] index_move(input logic [2:0] mag);
    logic [7:0] mv;
    unique case (mag)
      3'd4:    mv = 8'd2;
      3'd5:    mv = 8'd4;
      3'd6:    mv = 8'd7;
      3'd7:    mv = 8'd12;
      default: mv = 8'hff;
    endcase
    return mv;
  endfunction

  // Decodes one 4-bit code against the current state and returns the new state.
  function automatic nib_state_t nib_decode(input nib_state_t cur, input logic [3:0] code);
    logic [14:0] step;
    logic [17:0] diff;
    logic [18:0] dext;
    logic [18:0] acc;
    logic [7:0]  nidx;
    nib_state_t  nxt;
    step = step_lookup(cur.idx);
    diff = 18'(step >> 3);
    if (code[0]) begin
      diff = diff + 18'(step >> 2);
    end
    if (code[1]) begin
      diff = diff + 18'(step >> 1);
    end
    if (code[2]) begin
      diff = diff + 18'(step);
    end
    // Magnitude seven gets an extra half step on top of the usual weights.
    if (code[2:0] == 3'b111) begin
      diff = diff + 18'(step >> 1);
    end
    dext = {1'b0, diff};
    if (code[3]) begin
      dext = 19'(~dext + 19'd1);
    end
    acc = {{3{cur.pred[15]}}, cur.pred} + dext;
    if (acc[18] && (acc[17:15] != 3'b111)) begin
      nxt.pred = SampleMin;
    end else if (!acc[18] && (acc[17:15] != 3'b000)) begin
      nxt.pred = SampleMax;
    end else begin
      nxt.pred = acc[15:0];
    end

    nidx = {1'b0, cur.idx} + index_move(code[2:0]);
    if (nidx[7]) begin
      nxt.idx = 7'd0;
    end else if (nidx[6:0] > StepIndexMax) begin
      nxt.idx = StepIndexMax;
    end else begin
      nxt.idx = nidx[6:0];
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ===== sv/adnd_if.sv =====
// ----------------------------------------------------------------------------
// adnd_if
// Valid/ready channels for code bytes in and decoded samples out.
// ----------------------------------------------------------------------------
`default_nettype none

interface adnd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       restart;

  modport source (output valid, output code_byte, output restart, input ready);
  modport sink   (input valid, input code_byte, input restart, output ready);
endinterface

interface adnd_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] sample_wide;
  logic signed [7:0]  sample_narrow;
  logic              last;

  modport source (output valid, output sample_wide, output sample_narrow,
                  output last, input ready);
  modport sink   (input valid, input sample_wide, input sample_narrow,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== sv/adpcm_nibble_decoder.sv =====
// ----------------------------------------------------------------------------
// adpcm_nibble_decoder
// Two-code-per-byte ADPCM decoder with saturating 16-bit predictor.
// ----------------------------------------------------------------------------
// Each accepted byte is decoded in the cycle it is taken: both nibbles, low
// first, run through the step table and the predictor update in one pass, and
// the two samples land in a result register pair. Samples leave one per
// request on the output channel, the low-nibble sample first, the high-nibble
// sample with last set. The first sample is valid in the cycle after the byte is
// accepted. The output channel moves one sample per cycle while ready is high;
// each byte gives two, so a new byte waits for the previous byte's samples and is
// taken at the earliest in the same cycle its high-nibble sample leaves.
// Setting restart with a byte clears the predictor and step index first.
`default_nettype none

module adpcm_nibble_decoder (
  input  wire         clk_i,
  input  wire         rst_ni,
  adnd_in_if.sink     in_i,
  adnd_out_if.source  out_o
);

  import adnd_pkg::*;

  nib_state_t st_q, st_d;
  nib_state_t start_st, mid_st;
  logic [15:0] lo_q, hi_q;
  // Number of samples still waiting: 2 means the low one is next.
  logic [1:0] cnt_q, cnt_d;
  logic in_acc, out_acc;
  logic [15:0] sel;

  assign out_acc    = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    start_st = st_q;
    if (in_i.restart) begin
      start_st = '0;
    end
    mid_st = nib_decode(start_st, in_i.code_byte[3:0]);
    st_d   = st_q;
    cnt_d  = cnt_q;
    if (out_acc) begin
      cnt_d = cnt_q - 2'd1;
    end
    if (in_acc) begin
      st_d  = nib_decode(mid_st, in_i.code_byte[7:4]);
      cnt_d = 2'd2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      cnt_q <= 2'd0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lo_q <= mid_st.pred;
      hi_q <= st_d.pred;
    end
  end

  assign sel                 = (cnt_q == 2'd2) ? lo_q : hi_q;
  assign out_o.valid         = (cnt_q != 2'd0);
  assign out_o.sample_wide   = sel;
  assign out_o.sample_narrow = sel[15:8];
  assign out_o.last          = (cnt_q == 2'd1);

endmodule

`default_nettype wire
